FILE: design/shss_pkg.sv
// shss_pkg: shared types, codes and winding tables for the stepper half-step sequencer
// no dependencies; imported by stepper_half_step_sequencer
package shss_pkg;

  typedef logic [2:0] phase_t;
  typedef logic [3:0] coil_t;

  // request action codes
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // phase codes, none means no full phase reached yet
  localparam phase_t PHASE_NONE  = 3'd0;
  localparam phase_t PHASE_FIRST = 3'd1;
  localparam phase_t PHASE_LAST  = 3'd4;

  // two windings driven on each full phase
  function automatic coil_t full_coils(input phase_t p);
    coil_t c;
    unique case (p)
      3'd1:    c = 4'h5;
      3'd2:    c = 4'h6;
      3'd3:    c = 4'hA;
      3'd4:    c = 4'h9;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

  // single winding between phases, clockwise
  function automatic coil_t half_cw_coils(input phase_t p);
    coil_t c;
    unique case (p)
      3'd1:    c = 4'h4;
      3'd2:    c = 4'h2;
      3'd3:    c = 4'h8;
      3'd4:    c = 4'h1;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

  // single winding between phases, counter-clockwise
  function automatic coil_t half_ccw_coils(input phase_t p);
    coil_t c;
    unique case (p)
      3'd1:    c = 4'h1;
      3'd2:    c = 4'h4;
      3'd3:    c = 4'h2;
      3'd4:    c = 4'h8;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

  // phase after one full step; out-of-range phases count as none
  function automatic phase_t next_full_phase(input phase_t p, input logic cw);
    phase_t q;
    q = (p > PHASE_LAST) ? PHASE_NONE : p;
    if (cw) begin
      return (q == PHASE_LAST) ? PHASE_FIRST : phase_t'(q + 3'd1);
    end
    return (q <= PHASE_FIRST) ? PHASE_LAST : phase_t'(q - 3'd1);
  endfunction

endpackage

FILE: design/stepper_half_step_sequencer.sv
// stepper_half_step_sequencer: four-winding stepper sequencer, full and half stepping
// depends on shss_pkg for tables, phase codes and action codes
//
// usage
//   input channel (in_valid / in_stall): one request per item. action load takes a
//   signed step count and the stepping mode; action tick makes one step while the
//   count is nonzero, moving it one toward zero. the sign of the count sets the
//   direction, flipped when the reverse_direction register (cfg_wr_en/cfg_wr_data)
//   is set; write it only while the block is idle
//   result channel (out_valid / out_stall): exactly one request per input request,
//   carrying the coil drive, half-step position, remaining count and a moved flag
//   latency: a request accepted at one edge is offered on out_valid after the next
//   edge (input register, then the state update into the result register) and can
//   be taken at the edge after that
//   throughput: one request per cycle sustained, the state update is a single pass
//   of small logic (one 32-bit add and table lookups) between the two registers
//   stall: while out_stall holds a result, the input register keeps one request
//   and in_stall rises only once that register is also full; nothing is dropped
//   reset (rst_n low, synchronous): both registers empty, all sequencer state and
//   the reverse_direction register cleared, in_stall low
module stepper_half_step_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  // input requests
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic signed [15:0] in_target_steps,
  input  logic               in_half_mode,
  // result requests
  output logic               out_valid,
  input  logic               out_stall,
  output shss_pkg::coil_t    out_coils,
  output logic signed [31:0] out_position,
  output logic signed [15:0] out_steps_left,
  output logic               out_moved
);
  import shss_pkg::*;

  // configuration register
  logic rev_r;

  // input register
  logic        s1_valid_r;
  logic        s1_action_r;
  logic [15:0] s1_target_r;
  logic        s1_half_r;

  // sequencer state
  phase_t      phase_r,        phase_nxt;
  logic        half_pending_r, half_pending_nxt;
  coil_t       coil_r,         coil_nxt;
  logic [31:0] pos_r,          pos_nxt;
  logic [15:0] remaining_r,    remaining_nxt;
  logic        half_en_r,      half_en_nxt;
  logic        moved_nxt;

  // result register
  logic        out_valid_r;
  coil_t       out_coils_r;
  logic [31:0] out_pos_r;
  logic [15:0] out_left_r;
  logic        out_moved_r;

  logic in_take;
  logic s1_adv;
  logic stepping;
  logic negative;
  logic cw;
  logic do_full;
  logic [31:0] pos_m1;

  // input register advances when the result register is free or being emptied
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rev_r <= 1'b0;
    end else if (cfg_wr_en) begin
      rev_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r <= in_action;
      s1_target_r <= in_target_steps;
      s1_half_r   <= in_half_mode;
    end
  end

  // step decode
  assign stepping = (s1_action_r == ACT_TICK) && (remaining_r != 16'd0);
  assign negative = remaining_r[15];
  assign cw       = !negative ^ rev_r;
  assign do_full  = !half_en_r || half_pending_r;
  assign pos_m1   = pos_r - 32'd1;

  always_comb begin
    phase_nxt        = phase_r;
    half_pending_nxt = half_pending_r;
    coil_nxt         = coil_r;
    pos_nxt          = pos_r;
    remaining_nxt    = remaining_r;
    half_en_nxt      = half_en_r;
    moved_nxt        = 1'b0;
    if (s1_action_r == ACT_LOAD) begin
      // new count and mode, phase and position carry on
      remaining_nxt = s1_target_r;
      half_en_nxt   = s1_half_r;
    end else if (stepping) begin
      moved_nxt     = 1'b1;
      remaining_nxt = negative ? remaining_r + 16'd1 : remaining_r - 16'd1;
      if (do_full) begin
        phase_nxt = next_full_phase(phase_r, cw);
        coil_nxt  = full_coils(next_full_phase(phase_r, cw));
        if (half_en_r) begin
          // finishing a half step: snap to even against travel, then full step
          half_pending_nxt = 1'b0;
          pos_nxt = cw ? {pos_r[31:1], 1'b0} + 32'd2 : {pos_m1[31:1], 1'b0};
        end else begin
          pos_nxt = cw ? pos_r + 32'd2 : pos_r - 32'd2;
        end
      end else begin
        // first half: one winding between full phases
        half_pending_nxt = 1'b1;
        if (phase_r >= PHASE_FIRST && phase_r <= PHASE_LAST) begin
          if (cw) begin
            coil_nxt = half_cw_coils(phase_r);
            pos_nxt  = pos_r + 32'd1;
            if (phase_r == PHASE_LAST) begin
              phase_nxt = PHASE_NONE;
            end
          end else begin
            coil_nxt = half_ccw_coils(phase_r);
            pos_nxt  = pos_m1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PHASE_NONE;
      half_pending_r <= 1'b0;
      coil_r         <= 4'h0;
      pos_r          <= 32'd0;
      remaining_r    <= 16'd0;
      half_en_r      <= 1'b0;
    end else if (s1_adv) begin
      phase_r        <= phase_nxt;
      half_pending_r <= half_pending_nxt;
      coil_r         <= coil_nxt;
      pos_r          <= pos_nxt;
      remaining_r    <= remaining_nxt;
      half_en_r      <= half_en_nxt;
    end
  end

  // result register, refilled in the same cycle it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_coils_r <= coil_nxt;
      out_pos_r   <= pos_nxt;
      out_left_r  <= remaining_nxt;
      out_moved_r <= moved_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_coils      = out_coils_r;
  assign out_position   = $signed(out_pos_r);
  assign out_steps_left = $signed(out_left_r);
  assign out_moved      = out_moved_r;

endmodule

FILE: design/shss_checker.sv
// shss_checker: port-level checks for stepper_half_step_sequencer, with its bind
// depends on the top level's port names only
module shss_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [3:0]         out_coils,
  input logic signed [31:0] out_position,
  input logic signed [15:0] out_steps_left,
  input logic               out_moved
);

  logic [31:0] last_pos_r;
  logic [15:0] last_left_r;
  logic [31:0] pos_d;
  logic [15:0] left_d;

  // last delivered result, reset values match the sequencer's reset state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pos_r  <= 32'd0;
      last_left_r <= 16'd0;
    end else if (out_valid && !out_stall) begin
      last_pos_r  <= out_position;
      last_left_r <= out_steps_left;
    end
  end

  assign pos_d  = out_position - last_pos_r;
  assign left_d = out_steps_left - last_left_r;

  // reset empties both registers
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("valid or stall left set after reset");

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_coils) && $stable(out_position)
      && $stable(out_steps_left) && $stable(out_moved))
    else $error("result changed while stalled");

  // one step moves the position by at most one full step
  a_pos_delta: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_moved |-> pos_d == 32'd0 || pos_d == 32'd1 || pos_d == 32'd2
      || pos_d == 32'hFFFF_FFFF || pos_d == 32'hFFFF_FFFE)
    else $error("position jumped more than one step");

  // no step means no movement
  a_still: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_moved |-> pos_d == 32'd0)
    else $error("position changed without a step");

  // each step moves the count by one, in either direction
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_moved |-> left_d == 16'd1 || left_d == 16'hFFFF)
    else $error("step count not moved by one");

endmodule

bind stepper_half_step_sequencer shss_checker u_shss_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_coils      (out_coils),
  .out_position   (out_position),
  .out_steps_left (out_steps_left),
  .out_moved      (out_moved)
);

FILE: test/tb.sv
// tb: self-checking testbench for stepper_half_step_sequencer, full and half stepping
// depends on shss_pkg and the sequencer rtl; predicts every result and checks it field by field
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import shss_pkg::*;

  // margin after a drain, so no late result is still in flight before a register write
  localparam int SETTLE_CYCLES    = 4;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS      = 222;

  // winding tables packed one nibble per phase, phase 0 in the low nibble
  localparam logic [19:0] FULL_DRIVE     = 20'h9A650;
  localparam logic [19:0] HALF_CW_DRIVE  = 20'h18240;
  localparam logic [19:0] HALF_CCW_DRIVE = 20'h82410;

  typedef struct {
    logic               action;
    logic signed [15:0] target;
    logic               half;
  } step_req_t;

  typedef struct {
    coil_t              coils;
    logic signed [31:0] position;
    logic signed [15:0] steps_left;
    logic               moved;
  } coil_result_t;

  // dut connections, every input known from time zero
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_wr_data = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_action = 1'b0;
  logic signed [15:0] in_target_steps = '0;
  logic               in_half_mode = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  coil_t              out_coils;
  logic signed [31:0] out_position;
  logic signed [15:0] out_steps_left;
  logic               out_moved;

  // pending requests and the results they must produce
  step_req_t    req_queue[$];
  coil_result_t coil_expect_q[$];

  // predictor copy of the sequencer state
  phase_t             motor_phase = PHASE_NONE;
  logic               half_owed = 1'b0;
  coil_t              coil_drive = '0;
  logic signed [31:0] half_pos = '0;
  logic signed [15:0] steps_owed = '0;
  logic               half_mode_on = 1'b0;
  logic               reverse_dir = 1'b0;

  // traffic shaping, written by the stimulus, long hold and monitor processes
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_wanted = 1'b0;
  bit hold_out = 1'b0;
  logic req_taken = 1'b0;

  // bookkeeping
  int n_queued = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_steps = 0;
  int n_errors = 0;

  stepper_half_step_sequencer i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_target_steps (in_target_steps),
    .in_half_mode    (in_half_mode),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_coils       (out_coils),
    .out_position    (out_position),
    .out_steps_left  (out_steps_left),
    .out_moved       (out_moved)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one full step: two windings, position moves by a whole step of two halves
  function automatic void take_full_step(input logic cw);
    phase_t p;
    p = (motor_phase > PHASE_LAST) ? PHASE_NONE : motor_phase;
    if (cw) begin
      half_pos = half_pos + 32'sd2;
      p = (p == PHASE_LAST) ? PHASE_FIRST : phase_t'(p + 3'd1);
    end else begin
      half_pos = half_pos - 32'sd2;
      p = (p <= PHASE_FIRST) ? PHASE_LAST : phase_t'(p - 3'd1);
    end
    motor_phase = p;
    coil_drive = FULL_DRIVE[4*p +: 4];
  endfunction

  // advance the predicted sequencer by one request and return its result
  function automatic coil_result_t predict_coils(input step_req_t r);
    coil_result_t res;
    logic neg;
    logic cw;
    res.moved = 1'b0;
    if (r.action == ACT_LOAD) begin
      // a load replaces count and mode only, phase and pending half survive
      steps_owed = r.target;
      half_mode_on = r.half;
    end else if (steps_owed != 16'sd0) begin
      neg = steps_owed[15];
      cw = ~neg ^ reverse_dir;
      if (!half_mode_on) begin
        take_full_step(cw);
      end else if (half_owed) begin
        // finish the pending half: realign to an even position against travel
        if (cw) begin
          half_pos[0] = 1'b0;
        end else begin
          half_pos = half_pos + 32'sd1;
          half_pos[0] = 1'b0;
        end
        take_full_step(cw);
        half_owed = 1'b0;
      end else begin
        // from no phase yet, the half step leaves coils and position alone
        if (motor_phase >= PHASE_FIRST && motor_phase <= PHASE_LAST) begin
          if (cw) begin
            coil_drive = HALF_CW_DRIVE[4*motor_phase +: 4];
            half_pos = half_pos + 32'sd1;
            if (motor_phase == PHASE_LAST) motor_phase = PHASE_NONE;
          end else begin
            coil_drive = HALF_CCW_DRIVE[4*motor_phase +: 4];
            half_pos = half_pos - 32'sd1;
          end
        end
        half_owed = 1'b1;
      end
      steps_owed = neg ? steps_owed + 16'sd1 : steps_owed - 16'sd1;
      res.moved = 1'b1;
    end
    res.coils = coil_drive;
    res.position = half_pos;
    res.steps_left = steps_owed;
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    n_errors++;
  endtask

  // request driver: fed from req_queue, changes inputs on the falling edge
  always @(negedge clk) begin : request_driver
    step_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = req_queue.pop_front();
        in_valid <= 1'b1;
        in_action <= nxt.action;
        in_target_steps <= nxt.target;
        in_half_mode <= nxt.half;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure: random stalls, or solid while a long hold runs
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_out) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // long receiver hold, counted here so the sender keeps offering meanwhile
  always begin : long_hold
    wait (hold_wanted);
    hold_out = 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    hold_out = 1'b0;
    hold_wanted = 1'b0;
  end

  // monitor: predicts on every accepted request, checks every accepted result
  always @(posedge clk) begin : result_monitor
    step_req_t    seen;
    coil_result_t want;
    req_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && cfg_wr_en) reverse_dir = cfg_wr_data;
    if (rst_n && in_valid && !in_stall) begin
      seen.action = in_action;
      seen.target = in_target_steps;
      seen.half = in_half_mode;
      coil_expect_q.push_back(predict_coils(seen));
      n_accepted++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (coil_expect_q.size() == 0) begin
        flag_mismatch("result arrived with nothing expected");
      end else begin
        want = coil_expect_q.pop_front();
        n_checked++;
        if (want.moved) n_steps++;
        if (out_coils !== want.coils)
          flag_mismatch($sformatf("coils got %h want %h", out_coils, want.coils));
        if (out_position !== want.position)
          flag_mismatch($sformatf("position got %0d want %0d", out_position, want.position));
        if (out_steps_left !== want.steps_left)
          flag_mismatch($sformatf("steps_left got %0d want %0d",
                                  out_steps_left, want.steps_left));
        if (out_moved !== want.moved)
          flag_mismatch($sformatf("moved got %b want %b", out_moved, want.moved));
      end
    end
  end

  task automatic push_req(input logic act, input logic signed [15:0] tgt, input logic half);
    step_req_t r;
    r.action = act;
    r.target = tgt;
    r.half = half;
    req_queue.push_back(r);
    n_queued++;
  endtask

  // wait until every queued request is taken and every result is back
  task automatic drain();
    while (n_accepted != n_queued || coil_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reverse(input logic v);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    @(posedge clk);
  endtask

  // mostly load-then-tick motions with random content, some noise and cut-short moves
  task automatic queue_random(input int count);
    int made;
    int pick;
    int cnt;
    int mag;
    int ticks;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        push_req(1'($urandom_range(1)), 16'($urandom), 1'($urandom_range(1)));
        made++;
      end else begin
        if (pick < 20) begin
          case ($urandom_range(4))
            0:       cnt = 32767;
            1:       cnt = -32768;
            2:       cnt = 0;
            3:       cnt = -1;
            default: cnt = $urandom_range(65535) - 32768;
          endcase
          ticks = $urandom_range(12);
        end else begin
          mag = $urandom_range(12, 1);
          cnt = $urandom_range(1) ? -mag : mag;
          // most run to the end and idle a little, the rest are cut short by a reload
          ticks = (pick < 85) ? mag + $urandom_range(2) : $urandom_range(mag - 1);
        end
        push_req(ACT_LOAD, 16'(cnt), 1'($urandom_range(1)));
        made++;
        repeat (ticks) begin
          push_req(ACT_TICK, 16'($urandom), 1'($urandom_range(1)));
          made++;
        end
      end
    end
  endtask

  // one traffic phase; the mid-phase drain is the sender pausing for all results
  task automatic run_phase(input logic rev, input int send_pct, input int rx_pct,
                           input bit long_stall, input int count);
    drain();
    write_reverse(rev);
    send_idle_pct = send_pct;
    stall_pct = rx_pct;
    if (long_stall) hold_wanted = 1'b1;
    queue_random(count / 2);
    drain();
    queue_random(count - count / 2);
  endtask

  // main stimulus
  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    write_reverse(1'b0);

    // directed: idle tick at reset, half step from no phase, full steps round the table
    push_req(ACT_TICK, 16'sh7FFF, 1'b1);
    push_req(ACT_LOAD, 16'sd2, 1'b1);
    push_req(ACT_TICK, 16'sh0000, 1'b0);
    push_req(ACT_TICK, 16'shFFFF, 1'b1);
    push_req(ACT_LOAD, 16'sd3, 1'b0);
    repeat (3) push_req(ACT_TICK, 16'sh5555, 1'b0);
    // clockwise half from the last phase drops back to no phase, then lands on the first
    push_req(ACT_LOAD, 16'sd2, 1'b1);
    push_req(ACT_TICK, 16'shAAAA, 1'b1);
    push_req(ACT_TICK, 16'sh0000, 1'b0);
    push_req(ACT_TICK, 16'sh0000, 1'b0);
    // counter-clockwise half, then reloads mid-motion with a half still owed
    push_req(ACT_LOAD, -16'sd3, 1'b1);
    push_req(ACT_TICK, 16'sh0000, 1'b1);
    push_req(ACT_LOAD, 16'sh7FFF, 1'b0);
    push_req(ACT_TICK, 16'sh0000, 1'b0);
    push_req(ACT_LOAD, 16'sh8000, 1'b1);
    repeat (3) push_req(ACT_TICK, 16'shFFFF, 1'b1);
    push_req(ACT_LOAD, 16'sd0, 1'b1);
    push_req(ACT_TICK, 16'sh1234, 1'b0);

    // random phases over both direction settings and every idling mix
    run_phase(1'b1, 0, 0, 1'b0, PHASE_ITEMS);
    run_phase(1'b0, 66, 0, 1'b0, PHASE_ITEMS);
    run_phase(1'b1, 0, 66, 1'b0, PHASE_ITEMS);
    run_phase(1'b0, 37, 37, 1'b0, PHASE_ITEMS);
    run_phase(1'b1, 0, 0, 1'b1, PHASE_ITEMS);
    run_phase(1'b0, 37, 37, 1'b0, PHASE_ITEMS);
    drain();

    $display("covered %0d requests, %0d results checked, %0d of them steps",
             n_accepted, n_checked, n_steps);
    $display("both direction settings, full and half stepping, six idling phases");
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
